### rtl/core/soft_ack_arq_peer_tracker_defines.svh
// assertion macros for the soft ack peer tracker
// included by modules that carry concurrent checks; no other dependencies
`ifndef SOFT_ACK_ARQ_PEER_TRACKER_DEFINES_SVH
`define SOFT_ACK_ARQ_PEER_TRACKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SAPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SAPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sapt_pkg.sv
// shared types and constants for the soft ack peer tracker
// used by sapt_alu and soft_ack_arq_peer_tracker; no dependencies
package sapt_pkg;

    // default peer count and register reset values
    localparam int          PEERS_DEF      = 6;
    localparam logic [15:0] RTT_LIMIT_RST  = 16'd15000;
    localparam logic [3:0]  MISS_LIMIT_RST = 4'd10;
    localparam logic [3:0]  MISS_MAX       = 4'd15;

    // widths of the shared adder and the stream and config ports
    localparam int ALU_W    = 34;
    localparam int IN_W     = 120;
    localparam int S_USER_W = 2;
    localparam int OUT_W    = 64;
    localparam int CFG_W    = 16;
    localparam int CFG_A_W  = 1;

    // input item kinds
    typedef enum logic [1:0] {
        ACT_ACK         = 2'd0,
        ACT_FRAME_START = 2'd1,
        ACT_REPAIR_SCAN = 2'd2,
        ACT_EVALUATE    = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_RTT_LIMIT  = 1'b0,
        REG_MISS_LIMIT = 1'b1
    } cfg_reg_t;

    // one request to the shared adder
    typedef struct packed {
        logic [ALU_W-1:0] opa;
        logic [ALU_W-1:0] opb;
        logic             sub;
        logic             cin;
    } alu_req_t;

endpackage

### rtl/core/sapt_alu.sv
// shared add/subtract unit of the soft ack peer tracker
// depends on sapt_pkg for the request struct and width
module sapt_alu (
    input  sapt_pkg::alu_req_t           req,
    output logic [sapt_pkg::ALU_W-1:0]   sum
);

    logic [sapt_pkg::ALU_W-1:0] opb_eff;

    // subtraction inverts the second operand; carry in comes with the request
    assign opb_eff = req.sub ? ~req.opb : req.opb;
    assign sum     = req.opa + opb_eff + sapt_pkg::ALU_W'(req.cin);

endmodule

### rtl/core/soft_ack_arq_peer_tracker.sv
// soft ack peer tracker top level: sequencer, peer state and output register
// depends on sapt_pkg, sapt_alu and soft_ack_arq_peer_tracker_defines.svh
//
// Usage
// - s_ channel: one beat per item; s_tuser holds the kind (ack, frame start,
//   repair scan, evaluate), s_tdata the ack fields.
// - m_ channel: result beats; m_tlast marks the final beat of an item.
// - cfg port: cfg_wr_en writes cfg_wdata to register cfg_addr (0 round-trip
//   limit, 1 miss limit); write only while the block is idle.
// - An applied ack runs ten steps through one shared 34-bit adder (round trip,
//   limit compare, net time, average, offset); ACK_OUT then loads its beat
//   into the output register.
// - A rejected ack goes straight to ACK_OUT, which loads its beat.
// - A frame start gives no beat; the sequencer stays idle.
// - Repair scan and evaluate walk the peers one per cycle while the output
//   register can take a beat, giving PEERS beats.
// - s_tready is high only while the sequencer is idle; a finished beat may
//   wait in the output register while the next item is taken.
// - When the output register holds a beat and m_tready is low, the walk or ack step that emits waits in place.
// - Reset (aresetn low, synchronous) restores the register defaults, clears
//   all peer state to zero/offline and empties the output register.
`include "soft_ack_arq_peer_tracker_defines.svh"

module soft_ack_arq_peer_tracker #(
    parameter int PEERS = sapt_pkg::PEERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic [sapt_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [sapt_pkg::CFG_W-1:0]     cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[1:0]
    input  logic [sapt_pkg::S_USER_W-1:0]  s_tuser,
    // sink_id[3:0] packet_ok[4] now_us[36:5] echo_time_us[68:37]
    // turnaround_us[84:69] sink_send_time_us[116:85] pad[119:117]
    input  logic [sapt_pkg::IN_W-1:0]      s_tdata,
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // peer_index[3:0] ack_applied[4] retransmit[5] online[6] miss_count[10:7]
    // avg_round_trip_us[26:11] offset_est_us[58:27] pad[63:59]
    output logic [sapt_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    localparam int PEER_W = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int W      = sapt_pkg::ALU_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TOTAL, ST_CMP, ST_NET, ST_AVG7, ST_AVGSUM,
        ST_OFFX, ST_OFFA, ST_OFFB, ST_OFFD, ST_OFFR, ST_ACK_OUT, ST_WALK
    } state_t;

    // input field split
    sapt_pkg::action_t in_action;
    logic [3:0]        in_sink;
    logic              in_ok;

    assign in_action = sapt_pkg::action_t'(s_tuser);
    assign in_sink   = s_tdata[3:0];
    assign in_ok     = s_tdata[4];

    // control and config registers
    state_t             state_reg, state_next;
    sapt_pkg::action_t  act_reg, act_next;
    logic [3:0]         peer_reg, peer_next;
    logic               applied_reg, applied_next;
    logic               lt_reg, lt_next;
    logic [15:0]        rtt_limit_reg, rtt_limit_next;
    logic [3:0]         miss_limit_reg, miss_limit_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // item payload and scratch
    logic [31:0]        now_reg, now_next;
    logic [31:0]        echo_reg, echo_next;
    logic [15:0]        dwell_reg, dwell_next;
    logic [31:0]        send_reg, send_next;
    logic [31:0]        total_reg, total_next;
    logic [15:0]        net_reg, net_next;
    logic [W-1:0]       tmp_reg, tmp_next;
    logic [31:0]        ofa_reg, ofa_next;
    logic [sapt_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    // per-peer state
    logic [15:0]        avg_reg [PEERS];
    logic [15:0]        avg_next [PEERS];
    logic [31:0]        off_reg [PEERS];
    logic [31:0]        off_next [PEERS];
    logic [3:0]         miss_reg [PEERS];
    logic [3:0]         miss_next [PEERS];
    logic [PEERS-1:0]   acked_reg, acked_next;
    logic [PEERS-1:0]   online_reg, online_next;

    // shared adder
    sapt_pkg::alu_req_t alu_req;
    logic [W-1:0]       alu_sum;

    sapt_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // current peer view
    logic [PEER_W-1:0]  pidx;
    logic               in_range;
    logic [15:0]        avg_cur;
    logic [31:0]        off_cur;
    logic [3:0]         miss_cur;
    logic               online_cur;
    logic               acked_cur;
    logic [3:0]         miss_inc;
    logic               out_free;
    logic               walk_last;

    assign pidx       = peer_reg[PEER_W-1:0];
    assign in_range   = {1'b0, peer_reg} < 5'(PEERS);
    assign avg_cur    = in_range ? avg_reg[pidx] : 16'd0;
    assign off_cur    = in_range ? off_reg[pidx] : 32'd0;
    assign miss_cur   = in_range ? miss_reg[pidx] : 4'd0;
    assign online_cur = in_range ? online_reg[pidx] : 1'b0;
    assign acked_cur  = in_range ? acked_reg[pidx] : 1'b0;
    assign miss_inc   = (miss_cur < sapt_pkg::MISS_MAX) ? miss_cur + 4'd1 : miss_cur;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign walk_last  = peer_reg == 4'(PEERS - 1);

    // adder operand select per step
    always_comb begin
        alu_req = '0;
        case (state_reg)
            ST_TOTAL: begin
                alu_req.opa = W'(now_reg);
                alu_req.opb = W'(echo_reg);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_CMP: begin
                alu_req.opa = W'(total_reg);
                alu_req.opb = W'(rtt_limit_reg);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_NET: begin
                alu_req.opa = W'(total_reg);
                alu_req.opb = W'(dwell_reg);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_AVG7: begin
                alu_req.opa = W'({avg_cur, 3'b000});
                alu_req.opb = W'(avg_cur);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_AVGSUM: begin
                alu_req.opa = tmp_reg;
                alu_req.opb = W'(net_reg);
            end
            ST_OFFX: begin
                alu_req.opa = W'(send_reg);
                alu_req.opb = W'(dwell_reg);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_OFFA: begin
                alu_req.opa = W'(tmp_reg[31:0]);
                alu_req.opb = W'(echo_reg);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_OFFB: begin
                alu_req.opa = W'(now_reg);
                alu_req.opb = W'(send_reg);
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_OFFD: begin
                alu_req.opa = {{(W-32){ofa_reg[31]}}, ofa_reg};
                alu_req.opb = {{(W-32){tmp_reg[31]}}, tmp_reg[31:0]};
                alu_req.sub = 1'b1;
                alu_req.cin = 1'b1;
            end
            ST_OFFR: begin
                // halve toward zero: bump negative odd values before the shift
                alu_req.opa = tmp_reg;
                alu_req.cin = tmp_reg[W-1] & tmp_reg[0];
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // sequencer and state update
    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        peer_next       = peer_reg;
        applied_next    = applied_reg;
        lt_next         = lt_reg;
        rtt_limit_next  = rtt_limit_reg;
        miss_limit_next = miss_limit_reg;
        now_next        = now_reg;
        echo_next       = echo_reg;
        dwell_next      = dwell_reg;
        send_next       = send_reg;
        total_next      = total_reg;
        net_next        = net_reg;
        tmp_next        = tmp_reg;
        ofa_next        = ofa_reg;
        avg_next        = avg_reg;
        off_next        = off_reg;
        miss_next       = miss_reg;
        acked_next      = acked_reg;
        online_next     = online_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        // config writes
        if (cfg_wr_en) begin
            case (sapt_pkg::cfg_reg_t'(cfg_addr))
                sapt_pkg::REG_RTT_LIMIT:  rtt_limit_next  = cfg_wdata;
                sapt_pkg::REG_MISS_LIMIT: miss_limit_next = cfg_wdata[3:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = in_action;
                    peer_next  = in_sink;
                    now_next   = s_tdata[36:5];
                    echo_next  = s_tdata[68:37];
                    dwell_next = s_tdata[84:69];
                    send_next  = s_tdata[116:85];
                    case (in_action)
                        sapt_pkg::ACT_ACK: begin
                            if (in_ok && ({1'b0, in_sink} < 5'(PEERS))) begin
                                applied_next = 1'b1;
                                state_next   = ST_TOTAL;
                            end else begin
                                applied_next = 1'b0;
                                state_next   = ST_ACK_OUT;
                            end
                        end
                        sapt_pkg::ACT_FRAME_START: begin
                            acked_next = '0;
                        end
                        default: begin
                            peer_next  = 4'd0;
                            state_next = ST_WALK;
                        end
                    endcase
                end
            end
            ST_TOTAL: begin
                total_next = alu_sum[31:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                lt_next    = alu_sum[W-1];
                state_next = ST_NET;
            end
            ST_NET: begin
                net_next   = alu_sum[W-1] ? 16'd0 : alu_sum[15:0];
                state_next = ST_AVG7;
            end
            ST_AVG7: begin
                tmp_next   = alu_sum;
                state_next = ST_AVGSUM;
            end
            ST_AVGSUM: begin
                if (lt_reg) begin
                    avg_next[pidx] = (avg_cur == 16'd0) ? net_reg : alu_sum[18:3];
                end
                state_next = ST_OFFX;
            end
            ST_OFFX: begin
                tmp_next   = alu_sum;
                state_next = ST_OFFA;
            end
            ST_OFFA: begin
                ofa_next   = alu_sum[31:0];
                state_next = ST_OFFB;
            end
            ST_OFFB: begin
                tmp_next   = alu_sum;
                state_next = ST_OFFD;
            end
            ST_OFFD: begin
                tmp_next   = alu_sum;
                state_next = ST_OFFR;
            end
            ST_OFFR: begin
                off_next[pidx]    = alu_sum[32:1];
                acked_next[pidx]  = 1'b1;
                online_next[pidx] = 1'b1;
                miss_next[pidx]   = 4'd0;
                state_next        = ST_ACK_OUT;
            end
            ST_ACK_OUT: begin
                if (out_free) begin
                    m_tdata_next  = {5'd0, off_cur, avg_cur, miss_cur, online_cur,
                                     1'b0, applied_reg, peer_reg};
                    m_tlast_next  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    logic       rtx;
                    logic       on_new;
                    logic [3:0] miss_new;
                    rtx      = 1'b0;
                    on_new   = online_cur;
                    miss_new = miss_cur;
                    if (act_reg == sapt_pkg::ACT_REPAIR_SCAN) begin
                        rtx = online_cur && !acked_cur;
                    end else if (online_cur) begin
                        // evaluate: count a miss or clear on ack
                        if (!acked_cur) begin
                            miss_new = miss_inc;
                            on_new   = !(miss_inc >= miss_limit_reg);
                        end else begin
                            miss_new = 4'd0;
                        end
                    end
                    miss_next[pidx]   = miss_new;
                    online_next[pidx] = on_new;
                    m_tdata_next  = {5'd0, off_cur, avg_cur, miss_new, on_new,
                                     rtx, 1'b0, peer_reg};
                    m_tlast_next  = walk_last;
                    m_tvalid_next = 1'b1;
                    peer_next     = peer_reg + 4'd1;
                    if (walk_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers: payload first, control reset overrides
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        echo_reg    <= echo_next;
        dwell_reg   <= dwell_next;
        send_reg    <= send_next;
        total_reg   <= total_next;
        net_reg     <= net_next;
        tmp_reg     <= tmp_next;
        ofa_reg     <= ofa_next;
        act_reg     <= act_next;
        peer_reg    <= peer_next;
        applied_reg <= applied_next;
        lt_reg      <= lt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rtt_limit_reg  <= sapt_pkg::RTT_LIMIT_RST;
            miss_limit_reg <= sapt_pkg::MISS_LIMIT_RST;
            m_tvalid_reg   <= 1'b0;
            acked_reg      <= '0;
            online_reg     <= '0;
            for (int i = 0; i < PEERS; i++) begin
                avg_reg[i]  <= 16'd0;
                off_reg[i]  <= 32'd0;
                miss_reg[i] <= 4'd0;
            end
        end else begin
            state_reg      <= state_next;
            rtt_limit_reg  <= rtt_limit_next;
            miss_limit_reg <= miss_limit_next;
            m_tvalid_reg   <= m_tvalid_next;
            acked_reg      <= acked_next;
            online_reg     <= online_next;
            avg_reg        <= avg_next;
            off_reg        <= off_next;
            miss_reg       <= miss_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // check terms
    logic acked_offline;
    logic frame_take;
    logic applied_beat;
    logic applied_ok;

    assign acked_offline = |(acked_reg & ~online_reg);
    assign frame_take    = s_tvalid && s_tready && (in_action == sapt_pkg::ACT_FRAME_START);
    assign applied_beat  = m_tvalid && m_tdata[4];
    assign applied_ok    = m_tdata[6] && !m_tdata[5] && m_tlast;

    // checks
    `SAPT_ASSERT_SAME(a_acked_is_online, aclk, aresetn, 1'b1, !acked_offline, "acked peer offline")
    `SAPT_ASSERT_NEXT(a_frame_clears, aclk, aresetn, frame_take, !(|acked_reg), "stale ack mark")
    `SAPT_ASSERT_SAME(a_applied_online, aclk, aresetn, applied_beat, applied_ok, "bad applied beat")

endmodule
